@@ src/refcounted_packet_buffer_allocator_assert.svh @@
// Assertion macros shared by the allocator checker.
`ifndef REFCOUNTED_PACKET_BUFFER_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PACKET_BUFFER_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rpba_pkg.sv @@
// Shared types and constants of the packet buffer allocator.
`timescale 1ns / 1ps

package rpba_pkg;

  localparam int IDXW = 11;
  localparam int REQW = 2;
  localparam int STW  = 2;

  localparam logic [REQW-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQW-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQW-1:0] REQ_CLONE = 2'd2;

  localparam logic [STW-1:0] ST_OK      = 2'd0;
  localparam logic [STW-1:0] ST_NO_PKT  = 2'd1;
  localparam logic [STW-1:0] ST_NO_BUF  = 2'd2;
  localparam logic [STW-1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic accept;
    logic ref_rd;
    logic exec;
  } rpba_cmd_t;

  typedef struct packed {
    logic out_free;
  } rpba_sts_t;

endpackage

@@ src/refcounted_packet_buffer_allocator.sv @@
// Top level of the reference-counted packet buffer allocator.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one request: allocate, free or
//   clone, with a descriptor index for free and clone. Output channel
//   (out_valid / out_stall) returns exactly one result per request: new
//   descriptor, bound buffer, buffer-released flag and a status code.
//   Each request runs through accept with the map and free-stack tops read,
//   a reference count read at the mapped buffer, then the update. The two
//   dependent memory reads (map, then reference count) set those steps apart.
//   A result is registered in the update step; in_stall drops again in the
//   same cycle that the result appears at the output.
//   While the receiver stalls, the finished result stays in the output
//   register and the next request runs up to its update step, then waits.
//   Reset (rst_n low, synchronous) restores full free stacks and an empty map;
//   memory contents are not swept, low-water marks on the stacks stand in for
//   their reset values.

module refcounted_packet_buffer_allocator import rpba_pkg::*; #(
  parameter int NUM_PACKETS = 1024,
  parameter int NUM_BUFFERS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [REQW-1:0] in_req_type,
  input  logic [IDXW-1:0] in_packet_index,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IDXW-1:0] out_result_packet,
  output logic [IDXW-1:0] out_result_buffer,
  output logic            out_buffer_released,
  output logic [STW-1:0]  out_status
);

  rpba_cmd_t cmd;
  rpba_sts_t sts;

  rpba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpba_datapath #(
    .NUM_PACKETS (NUM_PACKETS),
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req_type),
    .in_packet_index     (in_packet_index),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_result_packet   (out_result_packet),
    .out_result_buffer   (out_result_buffer),
    .out_buffer_released (out_buffer_released),
    .out_status          (out_status)
  );

endmodule

@@ src/rpba_ctrl.sv @@
// Sequencer of the packet buffer allocator: accept, reference count read, update.
`timescale 1ns / 1ps

module rpba_ctrl import rpba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rpba_sts_t sts,
  output rpba_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REF  = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.accept = (state_r == S_IDLE) && in_valid;
  assign cmd.ref_rd = (state_r == S_REF);
  assign cmd.exec   = (state_r == S_EXE) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_REF;
      end
      S_REF: begin
        state_nxt = S_EXE;
      end
      S_EXE: begin
        // hold until the output register can take the result
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/rpba_datapath.sv @@
// Free stacks, descriptor map, reference counts and result register of the allocator.
`timescale 1ns / 1ps

module rpba_datapath import rpba_pkg::*; #(
  parameter int NUM_PACKETS = 1024,
  parameter int NUM_BUFFERS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rpba_cmd_t       cmd,
  output rpba_sts_t       sts,
  input  logic [REQW-1:0] in_req_type,
  input  logic [IDXW-1:0] in_packet_index,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [IDXW-1:0] out_result_packet,
  output logic [IDXW-1:0] out_result_buffer,
  output logic            out_buffer_released,
  output logic [STW-1:0]  out_status
);

  localparam int PIW = $clog2(NUM_PACKETS + 1);
  localparam int BIW = $clog2(NUM_BUFFERS + 1);
  localparam int PSW = $clog2(NUM_PACKETS);
  localparam int BSW = $clog2(NUM_BUFFERS);
  localparam int RCW = PIW;

  logic [PIW-1:0] pstk_mem [NUM_PACKETS];
  logic [BIW-1:0] bstk_mem [NUM_BUFFERS];
  logic [BIW-1:0] pmap_mem [NUM_PACKETS + 1];
  logic [RCW-1:0] rc_mem   [NUM_BUFFERS + 1];

  // Low-water marks: stack slots below them still hold their reset value.
  logic [PIW-1:0] pcnt_r, pcnt_nxt, plw_r, plw_nxt;
  logic [BIW-1:0] bcnt_r, bcnt_nxt, blw_r, blw_nxt;

  logic [REQW-1:0] req_r;
  logic [PIW-1:0]  px_r;
  logic            px_ok_r;
  logic [PIW-1:0]  ptop_rd_r;
  logic [BIW-1:0]  btop_rd_r;
  logic [BIW-1:0]  pmap_rd_r;
  logic [RCW-1:0]  rc_rd_r;

  logic            out_valid_r;
  logic [PIW-1:0]  res_pkt_r, res_pkt_nxt;
  logic [BIW-1:0]  res_buf_r, res_buf_nxt;
  logic            res_rel_r, res_rel_nxt;
  logic [STW-1:0]  res_st_r, res_st_nxt;

  logic [31:0]     in_px_w;
  logic            in_px_rng;
  logic            in_px_ok;
  logic [PIW-1:0]  map_raddr;
  logic [PSW-1:0]  ptop_raddr;
  logic [BSW-1:0]  btop_raddr;

  logic [PIW-1:0]  np;
  logic [BIW-1:0]  nb;
  logic            desc_ok;

  logic            pmap_we, pstk_we, bstk_we, rc_we;
  logic [PIW-1:0]  pmap_waddr;
  logic [BIW-1:0]  pmap_wdata;
  logic [BIW-1:0]  rc_waddr;
  logic [RCW-1:0]  rc_wdata;

  assign in_px_w    = 32'(in_packet_index);
  assign in_px_rng  = (in_px_w != 32'd0) && (in_px_w <= 32'(NUM_PACKETS));
  assign map_raddr  = in_px_rng ? in_px_w[PIW-1:0] : '0;
  // a descriptor above the packet low-water mark has had its map entry written
  assign in_px_ok   = in_px_rng && (in_px_w > 32'(plw_r));
  assign ptop_raddr = (pcnt_r == '0) ? '0 : PSW'(pcnt_r - 1'b1);
  assign btop_raddr = (bcnt_r == '0) ? '0 : BSW'(bcnt_r - 1'b1);

  // an untouched top slot holds its position plus one, which is the count
  assign np      = (pcnt_r == plw_r) ? pcnt_r : ptop_rd_r;
  assign nb      = (bcnt_r == blw_r) ? bcnt_r : btop_rd_r;
  assign desc_ok = px_ok_r && (pmap_rd_r != '0);

  always_comb begin
    res_pkt_nxt = '0;
    res_buf_nxt = '0;
    res_rel_nxt = 1'b0;
    res_st_nxt  = ST_OK;
    pcnt_nxt    = pcnt_r;
    bcnt_nxt    = bcnt_r;
    pmap_we     = 1'b0;
    pmap_waddr  = px_r;
    pmap_wdata  = '0;
    pstk_we     = 1'b0;
    bstk_we     = 1'b0;
    rc_we       = 1'b0;
    rc_waddr    = pmap_rd_r;
    rc_wdata    = '0;
    case (req_r)
      REQ_ALLOC: begin
        if (pcnt_r == '0) begin
          res_st_nxt = ST_NO_PKT;
        end else if (bcnt_r == '0) begin
          res_st_nxt = ST_NO_BUF;
        end else begin
          pcnt_nxt    = pcnt_r - 1'b1;
          bcnt_nxt    = bcnt_r - 1'b1;
          pmap_we     = 1'b1;
          pmap_waddr  = np;
          pmap_wdata  = nb;
          rc_we       = 1'b1;
          rc_waddr    = nb;
          rc_wdata    = RCW'(1);
          res_pkt_nxt = np;
          res_buf_nxt = nb;
        end
      end
      REQ_FREE: begin
        if (!desc_ok) begin
          res_st_nxt = ST_INVALID;
        end else begin
          pmap_we = 1'b1;
          if (pcnt_r < PIW'(NUM_PACKETS)) begin
            pstk_we  = 1'b1;
            pcnt_nxt = pcnt_r + 1'b1;
          end
          if (rc_rd_r <= RCW'(1)) begin
            if (bcnt_r < BIW'(NUM_BUFFERS)) begin
              bstk_we  = 1'b1;
              bcnt_nxt = bcnt_r + 1'b1;
            end
            res_rel_nxt = 1'b1;
          end else begin
            rc_we    = 1'b1;
            rc_wdata = rc_rd_r - 1'b1;
          end
          res_buf_nxt = pmap_rd_r;
        end
      end
      REQ_CLONE: begin
        if (!desc_ok) begin
          res_st_nxt = ST_INVALID;
        end else if (pcnt_r == '0) begin
          res_st_nxt = ST_NO_PKT;
        end else begin
          pcnt_nxt   = pcnt_r - 1'b1;
          pmap_we    = 1'b1;
          pmap_waddr = np;
          pmap_wdata = pmap_rd_r;
          // saturate the count at its field maximum
          if (rc_rd_r != '1) begin
            rc_we    = 1'b1;
            rc_wdata = rc_rd_r + 1'b1;
          end
          res_pkt_nxt = np;
          res_buf_nxt = pmap_rd_r;
        end
      end
      default: begin
        res_st_nxt = ST_INVALID;
      end
    endcase
    plw_nxt = (pcnt_nxt < plw_r) ? pcnt_nxt : plw_r;
    blw_nxt = (bcnt_nxt < blw_r) ? bcnt_nxt : blw_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r     <= in_req_type;
      px_r      <= map_raddr;
      px_ok_r   <= in_px_ok;
      pmap_rd_r <= pmap_mem[map_raddr];
      ptop_rd_r <= pstk_mem[ptop_raddr];
      btop_rd_r <= bstk_mem[btop_raddr];
    end
    if (cmd.ref_rd) begin
      rc_rd_r <= rc_mem[pmap_rd_r];
    end
    if (cmd.exec) begin
      if (pmap_we) pmap_mem[pmap_waddr] <= pmap_wdata;
      if (pstk_we) pstk_mem[PSW'(pcnt_r)] <= px_r;
      if (bstk_we) bstk_mem[BSW'(bcnt_r)] <= pmap_rd_r;
      if (rc_we)   rc_mem[rc_waddr] <= rc_wdata;
      res_pkt_r <= res_pkt_nxt;
      res_buf_r <= res_buf_nxt;
      res_rel_r <= res_rel_nxt;
      res_st_r  <= res_st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r      <= PIW'(NUM_PACKETS);
      plw_r       <= PIW'(NUM_PACKETS);
      bcnt_r      <= BIW'(NUM_BUFFERS);
      blw_r       <= BIW'(NUM_BUFFERS);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pcnt_r      <= pcnt_nxt;
        plw_r       <= plw_nxt;
        bcnt_r      <= bcnt_nxt;
        blw_r       <= blw_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free        = !out_valid_r || !out_stall;
  assign out_valid           = out_valid_r;
  assign out_result_packet   = IDXW'(res_pkt_r);
  assign out_result_buffer   = IDXW'(res_buf_r);
  assign out_buffer_released = res_rel_r;
  assign out_status          = res_st_r;

endmodule

@@ src/rpba_checker.sv @@
// Port-level checker of the packet buffer allocator, bound to the top level.
`timescale 1ns / 1ps
`include "refcounted_packet_buffer_allocator_assert.svh"

module rpba_checker import rpba_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [IDXW-1:0] out_result_packet,
  input logic [IDXW-1:0] out_result_buffer,
  input logic            out_buffer_released,
  input logic [STW-1:0]  out_status
);

  // one transaction in flight: the input closes right after an accept
  `RPBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not held after accept")

  `RPBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_result_buffer), "stalled result changed")

  `RPBA_ASSERT_NOW(a_ok_has_buffer, out_valid && out_status == ST_OK, out_result_buffer != '0, "ok result without buffer")

  `RPBA_ASSERT_NOW(a_fail_is_empty, out_valid && out_status != ST_OK, out_result_packet == '0 && out_result_buffer == '0 && !out_buffer_released, "failed result carries data")

endmodule

bind refcounted_packet_buffer_allocator rpba_checker u_rpba_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the reference-counted packet buffer allocator.
`timescale 1ns / 1ps

module testbench;
  import rpba_pkg::*;

  localparam int NUM_PKT     = 1024;
  localparam int NUM_BUF     = 1024;
  localparam int RAND_ITEMS  = 1650;
  localparam int PHASE_LEN   = 550;
  localparam int FILL_ITEMS  = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_DIR     = 18;

  // The request code that the block answers as invalid.
  localparam logic [REQW-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDXW-1:0] pkt_id;
    logic [IDXW-1:0] buf_id;
    logic            released;
    logic [STW-1:0]  status;
  } alloc_result_t;

  typedef struct packed {
    logic [REQW-1:0] rq;
    logic [IDXW-1:0] ix;
    logic            typed;
    alloc_result_t   want;
  } req_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [REQW-1:0] in_req_type = REQ_ALLOC;
  logic [IDXW-1:0] in_packet_index = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [IDXW-1:0] out_result_packet;
  logic [IDXW-1:0] out_result_buffer;
  logic            out_buffer_released;
  logic [STW-1:0]  out_status;

  // Allocator state as the testbench tracks it.
  logic [IDXW-1:0] desc_stack [NUM_PKT];
  logic [IDXW-1:0] bufr_stack [NUM_BUF];
  logic [IDXW-1:0] desc_to_buf [0:NUM_PKT];
  int              share_cnt [0:NUM_BUF];
  int              desc_free;
  int              bufr_free;
  logic [IDXW-1:0] live_descs [$];

  alloc_result_t   pending_results [$];
  int              send_idle = 29;
  int              recv_stall = 80;
  int              n_errors = 0;
  int              n_sent = 0;
  int              status_seen [4] = '{0, 0, 0, 0};
  int              n_released = 0;
  int              max_share = 0;
  int              min_desc_free = NUM_PKT;
  int              cycle_cnt = 0;

  // Directed rows; typed expectations follow from the reset stack order.
  req_row_t dir_rows [NUM_DIR] = '{
    '{REQ_ALLOC,  11'd0,    1'b1, '{11'd1024, 11'd1024, 1'b0, ST_OK}},
    '{REQ_ALLOC,  11'd2047, 1'b1, '{11'd1023, 11'd1023, 1'b0, ST_OK}},
    '{REQ_CLONE,  11'd1024, 1'b1, '{11'd1022, 11'd1024, 1'b0, ST_OK}},
    '{REQ_CLONE,  11'd1022, 1'b1, '{11'd1021, 11'd1024, 1'b0, ST_OK}},
    '{REQ_FREE,   11'd1024, 1'b1, '{11'd0,    11'd1024, 1'b0, ST_OK}},
    '{REQ_FREE,   11'd1024, 1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_FREE,   11'd0,    1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_CLONE,  11'd0,    1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_FREE,   11'd1025, 1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_CLONE,  11'd2047, 1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_UNUSED, 11'd5,    1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_FREE,   11'd1021, 1'b1, '{11'd0,    11'd1024, 1'b0, ST_OK}},
    '{REQ_FREE,   11'd1022, 1'b1, '{11'd0,    11'd1024, 1'b1, ST_OK}},
    '{REQ_ALLOC,  11'd1,    1'b0, '0},
    '{REQ_FREE,   11'd1023, 1'b0, '0},
    '{REQ_CLONE,  11'd1023, 1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_UNUSED, 11'd2047, 1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}},
    '{REQ_FREE,   11'd2047, 1'b1, '{11'd0,    11'd0,    1'b0, ST_INVALID}}
  };

  refcounted_packet_buffer_allocator #(
    .NUM_PACKETS(NUM_PKT),
    .NUM_BUFFERS(NUM_BUF)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_packet_index    (in_packet_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_packet  (out_result_packet),
    .out_result_buffer  (out_result_buffer),
    .out_buffer_released(out_buffer_released),
    .out_status         (out_status)
  );

  always #5 clk = ~clk;

  // Apply one request to the tracked state and return its result.
  function automatic alloc_result_t predict_request(input logic [REQW-1:0] rq,
                                                    input logic [IDXW-1:0] ix);
    alloc_result_t r;
    logic [IDXW-1:0] np;
    logic [IDXW-1:0] bx;
    bit in_use;
    r = '0;
    in_use = ix >= 1 && ix <= NUM_PKT && desc_to_buf[ix] != '0;
    case (rq)
      REQ_ALLOC: begin
        if (desc_free == 0) begin
          r.status = ST_NO_PKT;
        end else if (bufr_free == 0) begin
          r.status = ST_NO_BUF;
        end else begin
          desc_free--;
          np = desc_stack[desc_free];
          bufr_free--;
          bx = bufr_stack[bufr_free];
          desc_to_buf[np] = bx;
          share_cnt[bx] = 1;
          live_descs.push_back(np);
          r.pkt_id = np;
          r.buf_id = bx;
          r.status = ST_OK;
        end
      end
      REQ_FREE: begin
        if (!in_use) begin
          r.status = ST_INVALID;
        end else begin
          bx = desc_to_buf[ix];
          desc_to_buf[ix] = '0;
          if (desc_free < NUM_PKT) begin
            desc_stack[desc_free] = ix;
            desc_free++;
          end
          if (share_cnt[bx] <= 1) begin
            if (bufr_free < NUM_BUF) begin
              bufr_stack[bufr_free] = bx;
              bufr_free++;
            end
            r.released = 1'b1;
          end else begin
            share_cnt[bx]--;
          end
          for (int i = 0; i < live_descs.size(); i++) begin
            if (live_descs[i] == ix) begin
              live_descs.delete(i);
              break;
            end
          end
          r.buf_id = bx;
          r.status = ST_OK;
        end
      end
      REQ_CLONE: begin
        if (!in_use) begin
          r.status = ST_INVALID;
        end else if (desc_free == 0) begin
          r.status = ST_NO_PKT;
        end else begin
          bx = desc_to_buf[ix];
          desc_free--;
          np = desc_stack[desc_free];
          desc_to_buf[np] = bx;
          // Saturate at the width of the count field.
          if (share_cnt[bx] < (1 << IDXW) - 1) share_cnt[bx]++;
          if (share_cnt[bx] > max_share) max_share = share_cnt[bx];
          live_descs.push_back(np);
          r.pkt_id = np;
          r.buf_id = bx;
          r.status = ST_OK;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    if (desc_free < min_desc_free) min_desc_free = desc_free;
    return r;
  endfunction

  task automatic send_req(input logic [REQW-1:0] rq, input logic [IDXW-1:0] ix,
                          input logic typed, input alloc_result_t typed_res);
    alloc_result_t got;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= rq;
    in_packet_index <= ix;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = predict_request(rq, ix);
    pending_results.push_back(typed ? typed_res : got);
    n_sent++;
  endtask

  // Check each delivered transaction against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_packet !== want.pkt_id) begin
          $error("result_packet: expected %0d, got %0d", want.pkt_id, out_result_packet);
          n_errors++;
        end
        if (out_result_buffer !== want.buf_id) begin
          $error("result_buffer: expected %0d, got %0d", want.buf_id, out_result_buffer);
          n_errors++;
        end
        if (out_buffer_released !== want.released) begin
          $error("buffer_released: expected %0d, got %0d", want.released,
                 out_buffer_released);
          n_errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          n_errors++;
        end
        status_seen[want.status]++;
        if (want.released) n_released++;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int roll;
    int grow_pct;
    int free_pct;
    logic [REQW-1:0] rq;
    logic [IDXW-1:0] ix;
    for (int i = 0; i < NUM_PKT; i++) desc_stack[i] = IDXW'(i + 1);
    for (int i = 0; i < NUM_BUF; i++) bufr_stack[i] = IDXW'(i + 1);
    for (int i = 0; i <= NUM_PKT; i++) desc_to_buf[i] = '0;
    for (int i = 0; i <= NUM_BUF; i++) share_cnt[i] = 1;
    share_cnt[0] = 0;
    desc_free = NUM_PKT;
    bufr_free = NUM_BUF;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_req(dir_rows[i].rq, dir_rows[i].ix, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Hold off the sender until everything outstanding has drained.
      if (n == PHASE_LEN || n == 2 * PHASE_LEN || n == FILL_ITEMS) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (n == PHASE_LEN) begin
        send_idle  = 80;
        recv_stall = 29;
      end
      if (n == 2 * PHASE_LEN) begin
        send_idle  = 0;
        recv_stall = 0;
      end
      // Grow until the descriptors run out, then drain.
      grow_pct = (n < FILL_ITEMS) ? 95 : 10;
      free_pct = (n < FILL_ITEMS) ? 1 : 86;
      roll = $urandom_range(99);
      rq = REQ_ALLOC;
      ix = IDXW'($urandom_range(2047));
      if (roll < 100 - grow_pct - free_pct) begin
        rq = REQW'($urandom_range(3));
      end else if (roll < 100 - free_pct) begin
        if (live_descs.size() != 0 && $urandom_range(1) == 1) begin
          rq = REQ_CLONE;
          ix = live_descs[$urandom_range(live_descs.size() - 1)];
        end
      end else if (live_descs.size() != 0) begin
        rq = REQ_FREE;
        ix = live_descs[$urandom_range(live_descs.size() - 1)];
      end
      send_req(rq, ix, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests: %0d ok, %0d out of descriptors, %0d out of buffers, %0d invalid",
             n_sent, status_seen[ST_OK], status_seen[ST_NO_PKT], status_seen[ST_NO_BUF],
             status_seen[ST_INVALID]);
    $display("Buffers released %0d times, deepest sharing %0d, fewest free descriptors %0d",
             n_released, max_share, min_desc_free);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ refcounted_packet_buffer_allocator.f @@
+incdir+src
src/rpba_pkg.sv
src/rpba_ctrl.sv
src/rpba_datapath.sv
src/refcounted_packet_buffer_allocator.sv
src/rpba_checker.sv
test/testbench.sv
